FILE: rtl/min_tracking_stack_unit_assert.svh
// Assertion macros shared by the min-tracking stack RTL.
// MTSU_ASSERT checks under reset qualification; MTSU_ASSERT_ALWAYS checks at every edge.
`ifndef MIN_TRACKING_STACK_UNIT_ASSERT_SVH
`define MIN_TRACKING_STACK_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MTSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTSU_ASSERT(lbl, prop, msg)
`define MTSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/mtsu_pkg.sv
`timescale 1ns / 1ps

package mtsu_pkg;

  // Request kinds carried on in_tuser.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes carried on out_tuser.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Width of the depth field in a result.
  localparam int unsigned DEPTH_FIELD_W = 7;

  // Shift command broadcast to every cell of a chain.
  typedef struct packed {
    logic push;  // every entry moves one place toward the bottom
    logic pop;   // every entry moves one place toward the top
  } shift_cmd_t;

endpackage

FILE: rtl/mtsu_cell.sv
`timescale 1ns / 1ps

module mtsu_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk,
  input  mtsu_pkg::shift_cmd_t cmd,
  input  logic [WIDTH-1:0]    from_above,
  input  logic [WIDTH-1:0]    from_below,
  output logic [WIDTH-1:0]    entry
);

  logic [WIDTH-1:0] entry_r;
  logic [WIDTH-1:0] entry_nxt;

  // A push takes the neighbor above, a pop takes the neighbor below.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.push) begin
      entry_nxt = from_above;
    end else if (cmd.pop) begin
      entry_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: rtl/mtsu_chain.sv
`timescale 1ns / 1ps

module mtsu_chain #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk,
  input  mtsu_pkg::shift_cmd_t cmd,
  input  logic [WIDTH-1:0]    push_data,
  output logic [WIDTH-1:0]    top_entry,
  output logic [WIDTH-1:0]    next_entry
);

  logic [WIDTH-1:0] entries [DEPTH];

  // Cell 0 is the top of the stack; new data enters there on a push.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] above;
    logic [WIDTH-1:0] below;

    if (i == 0) begin : g_top
      assign above = push_data;
    end else begin : g_mid
      assign above = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_upper
      assign below = entries[i+1];
    end

    mtsu_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .from_above (above),
      .from_below (below),
      .entry      (entries[i])
    );
  end

  assign top_entry  = entries[0];
  assign next_entry = entries[1];

endmodule

FILE: rtl/min_tracking_stack_unit.sv
`timescale 1ns / 1ps
// A result is registered and becomes valid in the cycle after its request transaction is accepted.
// Throughput: one request per cycle while out_tready is high; every cell of both
// shift chains moves in the same cycle, so the output register sets the pace.
// Reset (rst_n low, synchronous): both entry counts and the output valid clear;
// stack cells are not reset and are only read after being written.

module min_tracking_stack_unit #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]          in_tdata,  // push_value
  input  logic                                     in_tuser,  // req_type

  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // top_value, min_value, depth (7 bits), is_empty
  output logic [((2*DATA_WIDTH+8+7)/8)*8-1:0]      out_tdata,
  output logic [1:0]                               out_tuser  // status
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((2 * DATA_WIDTH + 8 + 7) / 8) * 8;
  localparam int unsigned DFW   = mtsu_pkg::DEPTH_FIELD_W;

  `include "min_tracking_stack_unit_assert.svh"

  logic                  in_acc;
  logic                  req_pop;
  logic [DATA_WIDTH-1:0] push_value;

  logic [CW-1:0] val_cnt_r, val_cnt_nxt;
  logic [CW-1:0] min_cnt_r, min_cnt_nxt;

  logic [DATA_WIDTH-1:0] val_top, val_next;
  logic [DATA_WIDTH-1:0] min_top, min_next;

  logic push_ok, pop_ok, min_push, min_pop;
  logic full, empty;

  mtsu_pkg::shift_cmd_t val_cmd, min_cmd;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [DATA_WIDTH-1:0] top_r, top_nxt;
  logic [DATA_WIDTH-1:0] mval_r, mval_nxt;
  logic [DFW-1:0]        depth_r, depth_nxt;
  logic                  empty_r, empty_nxt;
  logic [DATA_WIDTH-1:0] top_sel, min_sel;
  logic [CW+DFW-1:0]     cnt_ext;

  // A new transaction is taken whenever the output register is free or draining.
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign req_pop    = (in_tuser == mtsu_pkg::REQ_POP);
  assign push_value = in_tdata[DATA_WIDTH-1:0];

  assign full  = (val_cnt_r == CW'(DEPTH));
  assign empty = (val_cnt_r == '0);

  // Decide what happens to each stack for this request.
  always_comb begin
    push_ok  = in_acc && !req_pop && !full;
    pop_ok   = in_acc && req_pop && !empty;
    min_push = push_ok && (min_cnt_r != CW'(DEPTH)) &&
               ((min_cnt_r == '0) || ($signed(push_value) <= $signed(min_top)));
    min_pop  = pop_ok && (min_cnt_r != '0) && (val_top == min_top);
  end

  assign val_cmd = '{push: push_ok, pop: pop_ok};
  assign min_cmd = '{push: min_push, pop: min_pop};

  mtsu_chain #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_val_chain (
    .clk        (clk),
    .cmd        (val_cmd),
    .push_data  (push_value),
    .top_entry  (val_top),
    .next_entry (val_next)
  );

  mtsu_chain #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_min_chain (
    .clk        (clk),
    .cmd        (min_cmd),
    .push_data  (push_value),
    .top_entry  (min_top),
    .next_entry (min_next)
  );

  // Entry counts follow the shift commands.
  always_comb begin
    val_cnt_nxt = val_cnt_r;
    if (push_ok) begin
      val_cnt_nxt = val_cnt_r + CW'(1);
    end else if (pop_ok) begin
      val_cnt_nxt = val_cnt_r - CW'(1);
    end

    min_cnt_nxt = min_cnt_r;
    if (min_push) begin
      min_cnt_nxt = min_cnt_r + CW'(1);
    end else if (min_pop) begin
      min_cnt_nxt = min_cnt_r - CW'(1);
    end
  end

  // Result fields describe the stack as it stands after the request.
  always_comb begin
    top_sel = val_top;
    if (push_ok) begin
      top_sel = push_value;
    end else if (pop_ok) begin
      top_sel = val_next;
    end

    min_sel = min_top;
    if (min_push) begin
      min_sel = push_value;
    end else if (min_pop) begin
      min_sel = min_next;
    end

    status_nxt = mtsu_pkg::STATUS_OK;
    if (in_acc && !req_pop && full) begin
      status_nxt = mtsu_pkg::STATUS_OVERFLOW;
    end else if (in_acc && req_pop && empty) begin
      status_nxt = mtsu_pkg::STATUS_UNDERFLOW;
    end

    cnt_ext   = (CW + DFW)'(val_cnt_nxt);
    depth_nxt = cnt_ext[DFW-1:0];
    empty_nxt = (val_cnt_nxt == '0);
    top_nxt   = empty_nxt ? '0 : top_sel;
    mval_nxt  = (!empty_nxt && (min_cnt_nxt != '0)) ? min_sel : '0;
  end

  // Output valid is set by an accepted request and cleared once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_cnt_r   <= '0;
      min_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      val_cnt_r   <= val_cnt_nxt;
      min_cnt_r   <= min_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads with each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      top_r    <= top_nxt;
      mval_r   <= mval_nxt;
      depth_r  <= depth_nxt;
      empty_r  <= empty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_W'({empty_r, depth_r, mval_r, top_r});

  `MTSU_ASSERT(a_min_le_val, (min_cnt_r <= val_cnt_r), "minimum stack deeper than main stack")
  `MTSU_ASSERT(a_cnt_bound, (val_cnt_r <= CW'(DEPTH)), "entry count beyond stack depth")
  `MTSU_ASSERT(a_push_count, (push_ok |=> (val_cnt_r == $past(val_cnt_r) + CW'(1))), "push did not grow the stack")
  `MTSU_ASSERT(a_underflow, ((in_acc && req_pop && empty) |=> (status_r == mtsu_pkg::STATUS_UNDERFLOW)), "pop on empty stack not flagged")
  `MTSU_ASSERT(a_min_nonempty, ((val_cnt_r != '0) |-> (min_cnt_r != '0)), "non-empty stack without a minimum")

endmodule
